>>> design/rgb_to_vga_attribute_defines.svh
// ----------------------------------------------------------------------------
// rgb_to_vga_attribute_defines
// Assertion macros for the rgb_to_vga_attribute block.
// ----------------------------------------------------------------------------
// Both macros expect signals named clk and arst_n in the scope of use.
`ifndef RGB_TO_VGA_ATTRIBUTE_DEFINES_SVH
`define RGB_TO_VGA_ATTRIBUTE_DEFINES_SVH

// Same-cycle implication.
`define RGB2VGA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_to_vga_attribute: assertion failed");

// Implication checked a fixed number of cycles later.
`define RGB2VGA_ASSERT_DELAY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("rgb_to_vga_attribute: delayed assertion failed");

`endif

>>> design/rgb2vga_pkg.sv
// ----------------------------------------------------------------------------
// rgb2vga_pkg
// Types, widths and constant tables shared by the RGB to VGA attribute block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgb2vga_pkg;

	localparam int RGB_W    = 24;
	localparam int CHAN_W   = 8;
	localparam int PAL_SIZE = 16;
	localparam int INDEX_W  = 4;
	localparam int ATTR_W   = 8;
	// worst case 255 * (3 + 6 + 10) = 4845
	localparam int DIST_W   = 13;
	localparam int QUAD     = 4;

	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	// palette in ANSI order
	localparam logic [RGB_W-1:0] PALETTE [PAL_SIZE] = '{
		24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
		24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
		24'h555555, 24'hFF5555, 24'h55AA55, 24'hFFFF55,
		24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
	};

	// ANSI index to VGA color number (red and blue bits swap places)
	localparam index_t ANSI_TO_VGA [PAL_SIZE] = '{
		4'd0, 4'd4,  4'd2,  4'd6,  4'd1, 4'd5,  4'd3,  4'd7,
		4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15
	};

endpackage

`default_nettype wire

>>> design/rgb2vga_color_if.sv
// ----------------------------------------------------------------------------
// rgb2vga_color_if
// Input channel: one foreground/background color pair per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgb2vga_color_if;
	import rgb2vga_pkg::*;

	logic             valid;
	logic             ready;
	logic [RGB_W-1:0] fg_rgb;
	logic [RGB_W-1:0] bg_rgb;

	modport source (output valid, output fg_rgb, output bg_rgb, input ready);
	modport sink   (input valid, input fg_rgb, input bg_rgb, output ready);
endinterface

`default_nettype wire

>>> design/rgb2vga_result_if.sv
// ----------------------------------------------------------------------------
// rgb2vga_result_if
// Output channel: attribute byte and the two palette indices per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgb2vga_result_if;
	import rgb2vga_pkg::*;

	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] attribute;
	index_t            fg_index;
	index_t            bg_index;

	modport source (output valid, output attribute, output fg_index, output bg_index,
		input ready);
	modport sink   (input valid, input attribute, input fg_index, input bg_index,
		output ready);
endinterface

`default_nettype wire

>>> design/rgb2vga_lane.sv
// ----------------------------------------------------------------------------
// rgb2vga_lane
// Nearest palette entry for one color: 16 distance units, then a registered
// minimum tree (16 -> 4 -> 1). Ties keep the lower index.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2vga_lane import rgb2vga_pkg::*; (
	input  logic             clk,
	input  pipe_ctl_t        ctl,
	input  logic [RGB_W-1:0] rgb,
	output index_t           index
);

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic dist_t weighted_dist(input logic [RGB_W-1:0] c,
		input logic [RGB_W-1:0] p);
		dist_t dr;
		dist_t dg;
		dist_t db;
		dr = dist_t'(abs_diff(c[23:16], p[23:16]));
		dg = dist_t'(abs_diff(c[15:8], p[15:8]));
		db = dist_t'(abs_diff(c[7:0], p[7:0]));
		return dr * dist_t'(3) + dg * dist_t'(6) + db * dist_t'(10);
	endfunction

	dist_t  dist_c    [PAL_SIZE];
	dist_t  dist_s1   [PAL_SIZE];
	dist_t  l1_d      [PAL_SIZE/2];
	index_t l1_i      [PAL_SIZE/2];
	dist_t  quad_d_c  [QUAD];
	index_t quad_i_c  [QUAD];
	dist_t  quad_d_s2 [QUAD];
	index_t quad_i_s2 [QUAD];
	dist_t  half_d    [QUAD/2];
	index_t half_i    [QUAD/2];
	index_t best_c;
	index_t index_s3;

	// stage 1: all distances
	always_comb begin
		for (int k = 0; k < PAL_SIZE; k++) begin
			dist_c[k] = weighted_dist(rgb, PALETTE[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			dist_s1 <= dist_c;
		end
	end

	// stage 2: first two tree levels; the higher index wins only if strictly closer
	always_comb begin
		for (int j = 0; j < PAL_SIZE/2; j++) begin
			if (dist_s1[2*j+1] < dist_s1[2*j]) begin
				l1_d[j] = dist_s1[2*j+1];
				l1_i[j] = INDEX_W'(2*j+1);
			end else begin
				l1_d[j] = dist_s1[2*j];
				l1_i[j] = INDEX_W'(2*j);
			end
		end
		for (int j = 0; j < QUAD; j++) begin
			if (l1_d[2*j+1] < l1_d[2*j]) begin
				quad_d_c[j] = l1_d[2*j+1];
				quad_i_c[j] = l1_i[2*j+1];
			end else begin
				quad_d_c[j] = l1_d[2*j];
				quad_i_c[j] = l1_i[2*j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			quad_d_s2 <= quad_d_c;
			quad_i_s2 <= quad_i_c;
		end
	end

	// stage 3: last two levels
	always_comb begin
		for (int j = 0; j < QUAD/2; j++) begin
			if (quad_d_s2[2*j+1] < quad_d_s2[2*j]) begin
				half_d[j] = quad_d_s2[2*j+1];
				half_i[j] = quad_i_s2[2*j+1];
			end else begin
				half_d[j] = quad_d_s2[2*j];
				half_i[j] = quad_i_s2[2*j];
			end
		end
		best_c = (half_d[1] < half_d[0]) ? half_i[1] : half_i[0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			index_s3 <= best_c;
		end
	end

	assign index = index_s3;

endmodule

`default_nettype wire

>>> design/rgb2vga_merge.sv
// ----------------------------------------------------------------------------
// rgb2vga_merge
// Combines both lane indices into the VGA attribute byte; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2vga_merge import rgb2vga_pkg::*; (
	input  logic              clk,
	input  pipe_ctl_t         ctl,
	input  index_t            fg_idx,
	input  index_t            bg_idx,
	output logic [ATTR_W-1:0] attribute,
	output index_t            fg_index,
	output index_t            bg_index
);

	logic [ATTR_W-1:0] attr_s4;
	index_t            fg_s4;
	index_t            bg_s4;

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			attr_s4 <= {ANSI_TO_VGA[bg_idx], ANSI_TO_VGA[fg_idx]};
			fg_s4   <= fg_idx;
			bg_s4   <= bg_idx;
		end
	end

	assign attribute = attr_s4;
	assign fg_index  = fg_s4;
	assign bg_index  = bg_s4;

endmodule

`default_nettype wire

>>> design/rgb_to_vga_attribute.sv
// Converts a foreground/background RGB pair to a VGA text attribute byte. One
// request is taken every cycle unless a full pipeline waits on the output; a
// result passes the distance units, two registered halves of the minimum tree
// and the output register. Each stage moves when the next has room, so input
// flows while a result waits, until earlier stages fill. Throughput is set by
// the two fully pipelined lanes, each with sixteen distance units in parallel.
// ----------------------------------------------------------------------------
// rgb_to_vga_attribute
// Top level: valid tracking per stage, two matching lanes and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_vga_attribute_defines.svh"

module rgb_to_vga_attribute import rgb2vga_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	rgb2vga_color_if.sink           color,
	rgb2vga_result_if.source        result
);

	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      v_s4;
	pipe_ctl_t ctl;
	index_t    fg_idx;
	index_t    bg_idx;

	// a stage loads when it is empty or its content moves on
	assign ctl.en_s4 = !v_s4 || result.ready;
	assign ctl.en_s3 = !v_s3 || ctl.en_s4;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign ctl.en_s1 = !v_s1 || ctl.en_s2;

	assign color.ready  = ctl.en_s1;
	assign result.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= color.valid;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	rgb2vga_lane u_lane_fg (
		.clk   (clk),
		.ctl   (ctl),
		.rgb   (color.fg_rgb),
		.index (fg_idx)
	);

	rgb2vga_lane u_lane_bg (
		.clk   (clk),
		.ctl   (ctl),
		.rgb   (color.bg_rgb),
		.index (bg_idx)
	);

	rgb2vga_merge u_merge (
		.clk       (clk),
		.ctl       (ctl),
		.fg_idx    (fg_idx),
		.bg_idx    (bg_idx),
		.attribute (result.attribute),
		.fg_index  (result.fg_index),
		.bg_index  (result.bg_index)
	);

	`RGB2VGA_ASSERT_IMPL(a_fg_nibble, result.valid,
		result.attribute[3:0] == ANSI_TO_VGA[result.fg_index])
	`RGB2VGA_ASSERT_IMPL(a_bg_nibble, result.valid,
		result.attribute[7:4] == ANSI_TO_VGA[result.bg_index])
	`RGB2VGA_ASSERT_DELAY(a_latency,
		color.valid && color.ready && !v_s1 && !v_s2 && !v_s3 && !v_s4, 4, result.valid)

endmodule

`default_nettype wire

>>> test/rgb_to_vga_attribute_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_vga_attribute_tb
// Drives color pairs into the quantizer with random gaps and output stalls.
// A local nearest-color predictor computes the attribute byte and both ANSI
// indices, and each returned request is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_to_vga_attribute_tb;
	import rgb2vga_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 12;

	typedef struct packed {
		logic [ATTR_W-1:0] attribute;
		index_t            fg_index;
		index_t            bg_index;
	} vga_attr_t;

	// 16-color text palette, ANSI order
	localparam logic [23:0] VGA16_RGB [16] = '{
		24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
		24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
		24'h555555, 24'hFF5555, 24'h55AA55, 24'hFFFF55,
		24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
	};

	logic clk = 1'b0;
	logic arst_n;

	rgb2vga_color_if  color_ch();
	rgb2vga_result_if result_ch();

	rgb_to_vga_attribute dut (
		.clk    (clk),
		.arst_n (arst_n),
		.color  (color_ch),
		.result (result_ch)
	);

	vga_attr_t pending_attrs[$];
	int        error_count = 0;
	int        quiet_cycles = 0;
	bit        gaps_on = 1'b1;
	bit        stalls_on = 1'b1;

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic int chan_dist(input logic [7:0] a, input logic [7:0] b);
		return (a >= b) ? int'(a - b) : int'(b - a);
	endfunction

	function automatic index_t nearest_ansi(input logic [23:0] rgb);
		int     best_d;
		int     d;
		index_t best;
		best   = '0;
		best_d = 32'h7FFFFFFF;
		for (int k = 0; k < 16; k++) begin
			d = chan_dist(rgb[23:16], VGA16_RGB[k][23:16]) * 3
				+ chan_dist(rgb[15:8], VGA16_RGB[k][15:8]) * 6
				+ chan_dist(rgb[7:0], VGA16_RGB[k][7:0]) * 10;
			// strict compare keeps the lowest index on a tie
			if (d < best_d) begin
				best_d = d;
				best   = index_t'(k);
			end
		end
		return best;
	endfunction

	function automatic vga_attr_t vga_attribute_of(input logic [23:0] fg,
		input logic [23:0] bg);
		vga_attr_t r;
		index_t    fi;
		index_t    bi;
		fi = nearest_ansi(fg);
		bi = nearest_ansi(bg);
		// ANSI to VGA: red and blue bits trade places
		r.attribute = {bi[3], bi[0], bi[1], bi[2], fi[3], fi[0], fi[1], fi[2]};
		r.fg_index  = fi;
		r.bg_index  = bi;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic send_colors(input logic [23:0] fg, input logic [23:0] bg);
		while (gaps_on && $urandom_range(99) < 12) begin
			color_ch.valid = 1'b0;
			@(negedge clk);
		end
		color_ch.valid  = 1'b1;
		color_ch.fg_rgb = fg;
		color_ch.bg_rgb = bg;
		do @(posedge clk); while (!color_ch.ready);
		pending_attrs.push_back(vga_attribute_of(fg, bg));
		@(negedge clk);
	endtask

	task automatic wait_all_returned();
		color_ch.valid = 1'b0;
		while (pending_attrs.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] jitter(input logic [7:0] c);
		int v;
		v = int'(c) + $urandom_range(16) - 8;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	// levels around palette levels and the midpoints between them
	function automatic logic [7:0] tie_level();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'h55;
			2: return 8'hAA;
			3: return 8'hFF;
			4: return 8'h2A;
			5: return 8'h2B;
			6: return 8'h7F;
			7: return 8'h80;
			8: return 8'hD4;
			default: return 8'hD5;
		endcase
	endfunction

	function automatic logic [23:0] random_color();
		logic [23:0] p;
		case ($urandom_range(3))
			0: return 24'($urandom());
			1: begin
				p = VGA16_RGB[$urandom_range(15)];
				return {jitter(p[23:16]), jitter(p[15:8]), jitter(p[7:0])};
			end
			2: return {tie_level(), tie_level(), tie_level()};
			default: return 24'($urandom_range(256));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_palette_exact();
		for (int k = 0; k < 16; k++)
			send_colors(VGA16_RGB[k], VGA16_RGB[15-k]);
	endtask

	task automatic test_extremes_and_ties();
		send_colors(24'h000000, 24'hFFFFFF);
		send_colors(24'hFF0000, 24'h00FF00);
		send_colors(24'h0000FF, 24'h000100);
		// small values are colors, not palette numbers
		send_colors(24'h000001, 24'h0000FF);
		// halfway between black and one primary: black wins ties, but 000055 is nearest to dark gray
		send_colors(24'h000055, 24'h550000);
		send_colors(24'h005500, 24'h555555);
		send_colors(24'hAAAAAA, 24'h808080);
		send_colors(24'hD4D4D4, 24'h7F7F7F);
	endtask

	task automatic test_random_mix(input int count);
		for (int n = 0; n < count; n++)
			send_colors(random_color(), random_color());
	endtask

	task automatic test_back_to_back(input int count);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		test_random_mix(count);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_pause_until_drained();
		test_random_mix(50);
		wait_all_returned();
		test_random_mix(50);
	endtask

	// ------------------------------------------------------------------------
	// Result sink, checker and watchdog
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		result_ch.ready = stalls_on ? ($urandom_range(99) >= 12) : 1'b1;
	end

	always @(posedge clk) begin
		vga_attr_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_attrs.size() == 0) begin
				$display("%0t: unexpected result attribute=%h fg_index=%h bg_index=%h",
					$time, result_ch.attribute, result_ch.fg_index, result_ch.bg_index);
				error_count++;
			end else begin
				want = pending_attrs.pop_front();
				if (result_ch.attribute !== want.attribute) begin
					$display("%0t: attribute expected %h actual %h",
						$time, want.attribute, result_ch.attribute);
					error_count++;
				end
				if (result_ch.fg_index !== want.fg_index) begin
					$display("%0t: fg_index expected %h actual %h",
						$time, want.fg_index, result_ch.fg_index);
					error_count++;
				end
				if (result_ch.bg_index !== want.bg_index) begin
					$display("%0t: bg_index expected %h actual %h",
						$time, want.bg_index, result_ch.bg_index);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((color_ch.valid && color_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog timeout, %0d requests outstanding",
				$time, pending_attrs.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		color_ch.valid  = 1'b0;
		color_ch.fg_rgb = '0;
		color_ch.bg_rgb = '0;
		result_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_palette_exact();
		test_extremes_and_ties();
		test_random_mix(600);
		test_back_to_back(300);
		test_pause_until_drained();
		test_random_mix(400);

		wait_all_returned();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
